### hdl/assert_macros.svh
// Assertion macros shared by the load-immediate expander RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

### hdl/lie_pkg.sv
// Types, constants and sizes shared by the load-immediate expander.
`timescale 1ns / 1ps
package lie_pkg;

    localparam int unsigned XLEN        = 64;
    localparam int unsigned MAX_LEVELS  = 6;
    localparam int unsigned LVL_W       = $clog2(MAX_LEVELS + 1);
    localparam int unsigned IDX_W       = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int unsigned MAX_RESULTS = 16;
    localparam int unsigned CNT_W       = $clog2(MAX_RESULTS);
    localparam int unsigned SH_W        = $clog2(XLEN);
    localparam int unsigned CTZ_STEPS   = SH_W;
    localparam int unsigned K_W         = $clog2(CTZ_STEPS);
    localparam int unsigned REG_W       = 5;
    localparam int unsigned IMM_W       = 20;
    localparam int unsigned LO_W        = 12;
    localparam int unsigned MID_W       = XLEN - LO_W + 1;
    localparam int unsigned HI_W        = 32;
    localparam int unsigned KIND_W      = 3;

    typedef enum logic [KIND_W-1:0] {
        OPK_ADDI  = 3'd0,
        OPK_AUIPC = 3'd1,
        OPK_LUI   = 3'd2,
        OPK_SLLI  = 3'd3,
        OPK_SUB   = 3'd4
    } t_opk;

    typedef struct packed {
        t_opk             kind;
        logic [REG_W-1:0] rd;
        logic [REG_W-1:0] rs1;
        logic [REG_W-1:0] rs2;
        logic [IMM_W-1:0] imm;
    } t_instr;

    typedef struct packed {
        logic   gen_v;
        logic   fin;
        t_instr instr;
    } t_emit_req;

    typedef struct packed {
        logic can_emit;
        logic flush_ok;
    } t_emit_sts;

    typedef struct packed {
        logic            start;
        logic [XLEN-1:0] x;
    } t_ctz_req;

    typedef struct packed {
        logic            busy;
        logic            done;
        logic [SH_W-1:0] cnt;
        logic [XLEN-1:0] val;
    } t_ctz_res;

    typedef struct packed {
        logic            neg;
        logic [LO_W-1:0] lo;
        logic [SH_W-1:0] sha;
    } t_frame;

endpackage

### hdl/lie_if.sv
// Valid/ready channel interfaces for the expander input and output items.
`timescale 1ns / 1ps
interface lie_in_if import lie_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [XLEN-1:0]  value;
    logic [XLEN-1:0]  code_address;
    logic [REG_W-1:0] dest_reg;

    modport source (output valid, value, code_address, dest_reg, input ready);
    modport sink   (input valid, value, code_address, dest_reg, output ready);
endinterface

interface lie_out_if import lie_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] opcode_kind;
    logic [REG_W-1:0]  rd_num;
    logic [REG_W-1:0]  rs1_num;
    logic [REG_W-1:0]  rs2_num;
    logic [IMM_W-1:0]  imm_bits;
    logic              last_instr;

    modport source (output valid, opcode_kind, rd_num, rs1_num, rs2_num, imm_bits,
                    last_instr, input ready);
    modport sink   (input valid, opcode_kind, rd_num, rs1_num, rs2_num, imm_bits,
                    last_instr, output ready);
endinterface

### hdl/lie_ctz.sv
// Iterative trailing-zero strip unit: binary search, one halving step per cycle.
`timescale 1ns / 1ps
module lie_ctz import lie_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_ctz_req i_req,
    output t_ctz_res o_res
);

    logic            r_busy;
    logic            r_done;
    logic [K_W-1:0]  r_k;
    logic [XLEN-1:0] r_x;
    logic [SH_W-1:0] r_n;

    logic [XLEN-1:0] low_mask;
    logic            strip;

    always_comb begin
        low_mask = ~({XLEN{1'b1}} << (1 << r_k));
        // a zero word has no trailing zeros to strip
        strip    = (r_x != '0) && ((r_x & low_mask) == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_k == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (i_req.start) begin
            r_x <= i_req.x;
            r_n <= '0;
            r_k <= K_W'(CTZ_STEPS - 1);
        end else if (r_busy) begin
            if (strip) begin
                r_x <= r_x >> (1 << r_k);
                r_n <= r_n + SH_W'(1 << r_k);
            end
            r_k <= r_k - 1'b1;
        end
    end

    assign o_res.busy = r_busy;
    assign o_res.done = r_done;
    assign o_res.cnt  = r_n;
    assign o_res.val  = r_x;

endmodule

### hdl/lie_outbuf.sv
// Output stage: one held instruction plus the output register, marks the last item.
`timescale 1ns / 1ps
module lie_outbuf import lie_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_emit_req        i_req,
    output t_emit_sts        o_sts,
    lie_out_if.source        o_out
);

    logic   r_pend_v;
    t_instr r_pend;
    logic   r_o_valid;
    t_instr r_out;
    logic   r_o_last;

    logic out_free;
    logic take;
    logic flush;

    always_comb begin
        out_free       = !r_o_valid || o_out.ready;
        o_sts.can_emit = !r_pend_v || out_free;
        o_sts.flush_ok = !r_pend_v || out_free;
        take           = i_req.gen_v && o_sts.can_emit;
        flush          = i_req.fin && r_pend_v && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (take) begin
                r_pend_v <= 1'b1;
                if (r_pend_v) begin
                    r_o_valid <= 1'b1;
                end else if (o_out.ready) begin
                    r_o_valid <= 1'b0;
                end
            end else if (flush) begin
                r_pend_v  <= 1'b0;
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
        // hold the newest instruction until we know whether another follows
        if (take) begin
            r_pend <= i_req.instr;
        end
        if ((take && r_pend_v) || flush) begin
            r_out    <= r_pend;
            r_o_last <= flush;
        end
    end

    assign o_out.valid       = r_o_valid;
    assign o_out.opcode_kind = r_out.kind;
    assign o_out.rd_num      = r_out.rd;
    assign o_out.rs1_num     = r_out.rs1;
    assign o_out.rs2_num     = r_out.rs2;
    assign o_out.imm_bits    = r_out.imm;
    assign o_out.last_instr  = r_o_last;

endmodule

### hdl/lie_seq.sv
// Expansion sequencer: per-level strategy choice, nesting stack and instruction issue.
`timescale 1ns / 1ps
module lie_seq import lie_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [XLEN-1:0]  i_value,
    input  logic [XLEN-1:0]  i_code_address,
    input  logic [REG_W-1:0] i_dest_reg,
    output logic             o_ready,
    output t_emit_req        o_emit,
    input  t_emit_sts        i_sts,
    output t_ctz_req         o_ctz,
    input  t_ctz_res         i_ctz
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EVAL,
        S_AUI_LO,
        S_CTZ_A,
        S_MID,
        S_CTZ_B,
        S_LEAF,
        S_L_LUI,
        S_L_SHB,
        S_L_ADDI,
        S_L_SHA,
        S_CTZ_C,
        S_POP,
        S_POP_SHA,
        S_FLUSH
    } t_state;

    t_state           r_state, n_state;
    logic [XLEN-1:0]  r_imm, n_imm;
    logic [XLEN-1:0]  r_pc, n_pc;
    logic [REG_W-1:0] r_rd, n_rd;
    logic [LVL_W-1:0] r_lvl, n_lvl;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [XLEN-1:0]  r_v, n_v;
    logic [LO_W-1:0]  r_lo, n_lo;
    logic [MID_W-1:0] r_mid, n_mid;
    logic [SH_W-1:0]  r_sha, n_sha;
    logic [SH_W-1:0]  r_shb, n_shb;
    t_frame           r_stack [MAX_LEVELS];

    logic             push;
    t_frame           push_frame;
    t_frame           top;
    logic [IDX_W-1:0] top_idx;
    logic [XLEN-1:0]  off;
    logic             imm_fits12;
    logic             off_fits;
    logic             imm_fits;
    logic [IMM_W-1:0] aui_hi;
    logic [MID_W-1:0] mid_calc;
    logic             mid_strip;
    logic [HI_W-1:0]  hi_calc;
    logic [XLEN-1:0]  split_mid;
    logic             take;

    function automatic t_instr mk(t_opk k, logic [REG_W-1:0] rd, logic [REG_W-1:0] rs1,
                                  logic [REG_W-1:0] rs2, logic [IMM_W-1:0] imm);
        t_instr t;
        t.kind = k;
        t.rd   = rd;
        t.rs1  = rs1;
        t.rs2  = rs2;
        t.imm  = imm;
        return t;
    endfunction

    always_comb begin
        top_idx    = IDX_W'(r_lvl - 1'b1);
        top        = r_stack[top_idx];
        off        = r_imm - r_pc;
        imm_fits12 = (&r_imm[XLEN-1:LO_W-1]) || !(|r_imm[XLEN-1:LO_W-1]);
        off_fits   = (&off[XLEN-1:HI_W-1]) || !(|off[XLEN-1:HI_W-1]);
        imm_fits   = (&r_imm[XLEN-1:HI_W-1]) || !(|r_imm[XLEN-1:HI_W-1]);
        // auipc upper part rounds up when the low part reads as negative
        aui_hi     = off[HI_W-1:LO_W] + IMM_W'(off[LO_W-1]);
        mid_calc   = {1'b0, r_v[XLEN-1:LO_W]} + MID_W'(r_v[LO_W-1]);
        mid_strip  = (mid_calc[MID_W-1:MID_W-2] == '0) && (mid_calc[MID_W-3:IMM_W] != '0);
        hi_calc    = r_mid[HI_W+IMM_W-1:IMM_W] + HI_W'(r_mid[IMM_W-1]);
        split_mid  = {i_ctz.val[XLEN-1:LO_W], {LO_W{1'b0}}}
                   + (i_ctz.val[LO_W-1] ? (XLEN'(1) << LO_W) : '0);
    end

    always_comb begin
        n_state = r_state;
        n_imm   = r_imm;
        n_pc    = r_pc;
        n_rd    = r_rd;
        n_lvl   = r_lvl;
        n_cnt   = r_cnt;
        n_v     = r_v;
        n_lo    = r_lo;
        n_mid   = r_mid;
        n_sha   = r_sha;
        n_shb   = r_shb;
        push       = 1'b0;
        push_frame = '0;
        o_emit     = '0;
        o_ctz      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_imm   = i_value;
                    n_pc    = i_code_address;
                    n_rd    = i_dest_reg;
                    n_lvl   = '0;
                    n_cnt   = '0;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (r_lvl == LVL_W'(MAX_LEVELS)) begin
                    // too deep: this level emits nothing
                    n_state = S_POP;
                end else if (imm_fits12) begin
                    o_emit.gen_v = 1'b1;
                    o_emit.instr = mk(OPK_ADDI, r_rd, '0, '0, IMM_W'(r_imm[LO_W-1:0]));
                    if (i_sts.can_emit) begin
                        n_state = S_POP;
                    end
                end else if (off_fits) begin
                    o_emit.gen_v = 1'b1;
                    o_emit.instr = mk(OPK_AUIPC, r_rd, '0, '0, aui_hi);
                    n_lo         = off[LO_W-1:0];
                    if (i_sts.can_emit) begin
                        n_state = S_AUI_LO;
                    end
                end else if (imm_fits) begin
                    n_v     = r_imm;
                    n_sha   = '0;
                    n_state = S_MID;
                end else begin
                    o_ctz.start = 1'b1;
                    o_ctz.x     = r_imm;
                    n_state     = S_CTZ_A;
                end
            end
            S_AUI_LO: begin
                if (r_lo != '0) begin
                    o_emit.gen_v = 1'b1;
                    o_emit.instr = mk(OPK_ADDI, r_rd, r_rd, '0, IMM_W'(r_lo));
                    if (i_sts.can_emit) begin
                        n_state = S_POP;
                    end
                end else begin
                    n_state = S_POP;
                end
            end
            S_CTZ_A: begin
                if (i_ctz.done) begin
                    n_v     = i_ctz.val;
                    n_sha   = i_ctz.cnt;
                    n_state = S_MID;
                end
            end
            S_MID: begin
                n_lo  = r_v[LO_W-1:0];
                n_mid = mid_calc;
                n_shb = '0;
                if (mid_strip) begin
                    o_ctz.start = 1'b1;
                    o_ctz.x     = XLEN'(mid_calc);
                    n_state     = S_CTZ_B;
                end else begin
                    n_state = S_LEAF;
                end
            end
            S_CTZ_B: begin
                if (i_ctz.done) begin
                    n_mid   = MID_W'(i_ctz.val);
                    n_shb   = i_ctz.cnt;
                    n_state = S_LEAF;
                end
            end
            S_LEAF: begin
                if (hi_calc == '0) begin
                    n_state = S_L_LUI;
                end else if (r_imm[XLEN-1]) begin
                    // load the negated value one level down, then sub from x0
                    push           = 1'b1;
                    push_frame.neg = 1'b1;
                    n_imm          = '0 - r_imm;
                    n_lvl          = r_lvl + 1'b1;
                    n_state        = S_EVAL;
                end else begin
                    o_ctz.start = 1'b1;
                    o_ctz.x     = r_imm;
                    n_state     = S_CTZ_C;
                end
            end
            S_L_LUI: begin
                if (r_mid[IMM_W-1:0] != '0) begin
                    o_emit.gen_v = 1'b1;
                    o_emit.instr = mk(OPK_LUI, r_rd, '0, '0, r_mid[IMM_W-1:0]);
                    if (i_sts.can_emit) begin
                        n_state = S_L_SHB;
                    end
                end else begin
                    n_state = S_L_ADDI;
                end
            end
            S_L_SHB: begin
                if (r_shb != '0) begin
                    o_emit.gen_v = 1'b1;
                    o_emit.instr = mk(OPK_SLLI, r_rd, r_rd, '0, IMM_W'(r_shb));
                    if (i_sts.can_emit) begin
                        n_state = S_L_ADDI;
                    end
                end else begin
                    n_state = S_L_ADDI;
                end
            end
            S_L_ADDI: begin
                if (r_lo != '0) begin
                    o_emit.gen_v = 1'b1;
                    o_emit.instr = mk(OPK_ADDI, r_rd,
                                      (r_mid[IMM_W-1:0] != '0) ? r_rd : '0, '0,
                                      IMM_W'(r_lo));
                    if (i_sts.can_emit) begin
                        n_state = S_L_SHA;
                    end
                end else begin
                    n_state = S_POP;
                end
            end
            S_L_SHA: begin
                if (r_sha != '0) begin
                    o_emit.gen_v = 1'b1;
                    o_emit.instr = mk(OPK_SLLI, r_rd, r_rd, '0, IMM_W'(r_sha));
                    if (i_sts.can_emit) begin
                        n_state = S_POP;
                    end
                end else begin
                    n_state = S_POP;
                end
            end
            S_CTZ_C: begin
                if (i_ctz.done) begin
                    // split: upper part goes one level down, low part is added after
                    push           = 1'b1;
                    push_frame.neg = 1'b0;
                    push_frame.lo  = i_ctz.val[LO_W-1:0];
                    push_frame.sha = i_ctz.cnt;
                    n_imm          = split_mid;
                    n_lvl          = r_lvl + 1'b1;
                    n_state        = S_EVAL;
                end
            end
            S_POP: begin
                if (r_lvl == '0) begin
                    n_state = S_FLUSH;
                end else if (top.neg) begin
                    o_emit.gen_v = 1'b1;
                    o_emit.instr = mk(OPK_SUB, r_rd, '0, r_rd, '0);
                    if (i_sts.can_emit) begin
                        n_lvl = r_lvl - 1'b1;
                    end
                end else if (top.lo != '0) begin
                    o_emit.gen_v = 1'b1;
                    o_emit.instr = mk(OPK_ADDI, r_rd, r_rd, '0, IMM_W'(top.lo));
                    if (i_sts.can_emit) begin
                        n_state = S_POP_SHA;
                    end
                end else begin
                    n_state = S_POP_SHA;
                end
            end
            S_POP_SHA: begin
                if (top.sha != '0) begin
                    o_emit.gen_v = 1'b1;
                    o_emit.instr = mk(OPK_SLLI, r_rd, r_rd, '0, IMM_W'(top.sha));
                    if (i_sts.can_emit) begin
                        n_lvl   = r_lvl - 1'b1;
                        n_state = S_POP;
                    end
                end else begin
                    n_lvl   = r_lvl - 1'b1;
                    n_state = S_POP;
                end
            end
            S_FLUSH: begin
                o_emit.fin = 1'b1;
                if (i_sts.flush_ok) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        take = o_emit.gen_v && i_sts.can_emit;
        if (take) begin
            n_cnt = r_cnt + 1'b1;
            // drop everything past the result limit
            if (r_cnt == CNT_W'(MAX_RESULTS - 1)) begin
                n_state = S_FLUSH;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lvl   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_lvl   <= n_lvl;
            r_cnt   <= n_cnt;
        end
        r_imm <= n_imm;
        r_pc  <= n_pc;
        r_rd  <= n_rd;
        r_v   <= n_v;
        r_lo  <= n_lo;
        r_mid <= n_mid;
        r_sha <= n_sha;
        r_shb <= n_shb;
        if (push) begin
            r_stack[IDX_W'(r_lvl)] <= push_frame;
        end
    end

    assign o_ready = (r_state == S_IDLE);

endmodule

### hdl/load_immediate_expander_top.sv
// Expansion: each nesting level makes at most three uses of the trailing-zero unit,
// plus issue steps; at most one instruction is issued per cycle, and none while the
// output stage stalls; nesting is at most MAX_LEVELS deep, 16 results.
// Throughput: one item at a time, set by the shared trailing-zero unit and sequencer.
// Reset: synchronous, active low; clears sequencer, unit and output valid state.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module load_immediate_expander_top import lie_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lie_in_if.sink    i_in,
    lie_out_if.source o_out
);

    t_emit_req emit_req;
    t_emit_sts emit_sts;
    t_ctz_req  ctz_req;
    t_ctz_res  ctz_res;
    logic      seq_ready;

    lie_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in.valid),
        .i_value        (i_in.value),
        .i_code_address (i_in.code_address),
        .i_dest_reg     (i_in.dest_reg),
        .o_ready        (seq_ready),
        .o_emit         (emit_req),
        .i_sts          (emit_sts),
        .o_ctz          (ctz_req),
        .i_ctz          (ctz_res)
    );

    lie_ctz u_ctz (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ctz_req),
        .o_res   (ctz_res)
    );

    lie_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (emit_req),
        .o_sts   (emit_sts),
        .o_out   (o_out)
    );

    assign i_in.ready = seq_ready;

    `ASSERT_PROP(a_busy_after_accept, i_clk, i_rst_n, (i_in.valid && i_in.ready) |=> !i_in.ready, "ready high right after an accepted item")
    `ASSERT_NEVER(a_ctz_restart, i_clk, i_rst_n, ctz_req.start && ctz_res.busy, "trailing-zero unit restarted while busy")
    `ASSERT_PROP(a_ctz_latency, i_clk, i_rst_n, ctz_req.start |-> ##(CTZ_STEPS + 1) ctz_res.done, "trailing-zero result late")
    `ASSERT_NEVER(a_fin_with_issue, i_clk, i_rst_n, emit_req.fin && emit_req.gen_v, "flush requested together with an instruction")

endmodule

### tb/tb_load_immediate_expander_top.sv
// Self-checking testbench for the RV64 load-immediate expander.
`timescale 1ns / 1ps
module tb_load_immediate_expander_top;
    import lie_pkg::*;

    localparam int unsigned N_DIRECTED   = 24;
    localparam int unsigned N_RANDOM     = 126;
    localparam int unsigned N_CALM       = 30;
    localparam int unsigned HOLD_AT      = 40;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned DRAIN_CYCLES = 200;
    localparam int unsigned DRAIN_LIMIT  = 5000;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    typedef struct packed {
        t_instr instr;
        logic   last;
    } t_exp_instr;

    // One directed constant; fixed_exp rows carry a single expected instruction.
    typedef struct packed {
        logic [XLEN-1:0]  value;
        logic [XLEN-1:0]  addr;
        logic [REG_W-1:0] rd;
        logic             fixed_exp;
        t_opk             kind;
        logic [IMM_W-1:0] imm;
    } t_const_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lie_in_if  in_ch ();
    lie_out_if out_ch ();

    load_immediate_expander_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_exp_instr       pending_instrs[$];
    t_instr           seq_buf [MAX_RESULTS];
    int unsigned      seq_len;
    logic [REG_W-1:0] seq_rd;
    int unsigned      error_count = 0;
    bit               idle_on = 1'b1;
    bit               hold_req = 1'b0;

    t_const_row const_rows [N_DIRECTED] = '{
        '{64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000, 5'd0,  1'b1, OPK_ADDI,  20'h000},
        '{64'h0000_0000_0000_07FF, 64'hFFFF_FFFF_FFFF_FFFF, 5'd31, 1'b1, OPK_ADDI,  20'h7FF},
        '{64'hFFFF_FFFF_FFFF_F800, 64'h0000_0000_0000_0000, 5'd5,  1'b1, OPK_ADDI,  20'h800},
        '{64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 5'd17, 1'b1, OPK_ADDI,  20'hFFF},
        '{64'h0000_0000_1234_5000, 64'h0000_0000_1234_5000, 5'd3,  1'b1, OPK_AUIPC, 20'h000},
        '{64'h0000_0000_4000_0123, 64'h0000_0000_4000_0000, 5'd9,  1'b0, OPK_ADDI,  20'h0},
        // auipc carry that wraps the upper part to zero
        '{64'h0000_0000_FFFF_F800, 64'h0000_0001_0000_0000, 5'd12, 1'b0, OPK_ADDI,  20'h0},
        '{64'h0000_0000_8000_0800, 64'h0000_0000_0000_1000, 5'd14, 1'b0, OPK_ADDI,  20'h0},
        '{64'h0000_0010_7FFF_FFFF, 64'h0000_0010_0000_0000, 5'd15, 1'b0, OPK_ADDI,  20'h0},
        '{64'h0000_000F_8000_0000, 64'h0000_0010_0000_0000, 5'd16, 1'b0, OPK_ADDI,  20'h0},
        // offset wraps around the top of the address space
        '{64'h0000_0000_0000_1000, 64'hFFFF_FFFF_FFFF_F000, 5'd18, 1'b0, OPK_ADDI,  20'h0},
        '{64'h7FFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000, 5'd31, 1'b0, OPK_ADDI,  20'h0},
        '{64'h8000_0000_0000_0000, 64'h0000_0000_0000_0000, 5'd1,  1'b0, OPK_ADDI,  20'h0},
        '{64'h8000_0000_0000_0001, 64'h0000_0000_0000_0000, 5'd2,  1'b0, OPK_ADDI,  20'h0},
        '{64'h0000_0000_0000_0800, 64'h8000_0000_0000_0000, 5'd4,  1'b0, OPK_ADDI,  20'h0},
        '{64'h0000_0000_7FFF_F800, 64'hFFFF_0000_0000_0000, 5'd6,  1'b0, OPK_ADDI,  20'h0},
        '{64'h0000_1234_0000_0000, 64'h0000_0000_0000_0000, 5'd8,  1'b0, OPK_ADDI,  20'h0},
        '{64'h1234_5678_9ABC_DEF1, 64'h0000_0000_0000_0000, 5'd7,  1'b0, OPK_ADDI,  20'h0},
        '{64'h5555_5555_5555_5555, 64'h0000_0000_0000_1000, 5'd21, 1'b0, OPK_ADDI,  20'h0},
        '{64'hAAAA_AAAA_AAAA_AAAB, 64'h0000_0000_0000_0000, 5'd10, 1'b0, OPK_ADDI,  20'h0},
        '{64'h7FF7_FF7F_F7FF_7FF7, 64'hFFFF_FFFF_FFFF_FFFF, 5'd30, 1'b0, OPK_ADDI,  20'h0},
        '{64'hFFFF_FFFF_0000_0001, 64'h0000_0000_0000_0000, 5'd11, 1'b0, OPK_ADDI,  20'h0},
        '{64'h0000_0000_8000_0000, 64'h0000_0000_0000_0000, 5'd13, 1'b0, OPK_ADDI,  20'h0},
        '{64'hFFFF_FFFF_7FFF_FFFF, 64'h0000_0000_0000_0000, 5'd29, 1'b0, OPK_ADDI,  20'h0}
    };

    function automatic bit fits_s32(logic [XLEN-1:0] x);
        return (x + 64'h8000_0000) < 64'h1_0000_0000;
    endfunction

    function automatic logic [XLEN-1:0] count_low_zeros(logic [XLEN-1:0] x);
        logic [XLEN-1:0] n;
        n = '0;
        while (x != '0 && !x[0] && n < XLEN) begin
            x = x >> 1;
            n++;
        end
        return n;
    endfunction

    // Drop anything past the result limit.
    function automatic void put_instr(t_opk kind, logic [REG_W-1:0] rs1,
                                      logic [REG_W-1:0] rs2, logic [IMM_W-1:0] imm);
        t_instr ins;
        if (seq_len < MAX_RESULTS) begin
            ins.kind = kind;
            ins.rd   = seq_rd;
            ins.rs1  = rs1;
            ins.rs2  = rs2;
            ins.imm  = imm;
            seq_buf[seq_len] = ins;
            seq_len++;
        end
    endfunction

    // Nested loads always come first, so walk down the levels, then unwind the
    // per-level tails (sub, or addi/slli) innermost first.
    function automatic void queue_expected_instrs(logic [XLEN-1:0] value,
                                                  logic [XLEN-1:0] pc, logic [REG_W-1:0] rd);
        logic [XLEN-1:0] imm, off, v, lo, mid, hi, sha, shb;
        bit              neg_at [MAX_LEVELS];
        logic [LO_W-1:0] lo_at  [MAX_LEVELS];
        logic [SH_W-1:0] sha_at [MAX_LEVELS];
        int              depth;
        bit              done;
        t_exp_instr      want;
        seq_len = 0;
        seq_rd  = rd;
        imm     = value;
        depth   = 0;
        done    = 1'b0;
        while (!done && depth < MAX_LEVELS) begin
            off = imm - pc;
            if (imm + 64'h800 < 64'h1000) begin
                put_instr(OPK_ADDI, '0, '0, IMM_W'(imm[LO_W-1:0]));
                done = 1'b1;
            end else if (fits_s32(off)) begin
                lo = off & 64'hFFF;
                hi = (off >> 12) & 64'hF_FFFF;
                if (lo >= 64'h800)
                    hi++;
                put_instr(OPK_AUIPC, '0, '0, hi[IMM_W-1:0]);
                if (lo != '0)
                    put_instr(OPK_ADDI, rd, '0, IMM_W'(lo[LO_W-1:0]));
                done = 1'b1;
            end else begin
                v   = imm;
                sha = '0;
                if (!fits_s32(imm)) begin
                    sha = count_low_zeros(v);
                    v   = v >> sha;
                end
                lo  = v & 64'hFFF;
                mid = v >> 12;
                if (lo >= 64'h800)
                    mid++;
                shb = '0;
                if (mid >= 64'h10_0000 && (mid >> 51) == '0) begin
                    shb = count_low_zeros(mid);
                    mid = mid >> shb;
                end
                hi  = mid >> 20;
                mid = mid & 64'hF_FFFF;
                if (mid >= 64'h8_0000)
                    hi++;
                hi = hi & 64'hFFFF_FFFF;
                if (hi == '0) begin
                    if (mid != '0) begin
                        put_instr(OPK_LUI, '0, '0, mid[IMM_W-1:0]);
                        if (shb != '0)
                            put_instr(OPK_SLLI, rd, '0, shb[IMM_W-1:0]);
                    end
                    if (lo != '0) begin
                        put_instr(OPK_ADDI, (mid != '0) ? rd : '0, '0, IMM_W'(lo[LO_W-1:0]));
                        if (sha != '0)
                            put_instr(OPK_SLLI, rd, '0, sha[IMM_W-1:0]);
                    end
                    done = 1'b1;
                end else if (imm[XLEN-1]) begin
                    neg_at[depth] = 1'b1;
                    imm = -imm;
                    depth++;
                end else begin
                    v   = imm;
                    sha = count_low_zeros(v);
                    v   = v >> sha;
                    lo  = v & 64'hFFF;
                    mid = v ^ lo;
                    if (lo >= 64'h800)
                        mid += 64'h1000;
                    neg_at[depth] = 1'b0;
                    lo_at[depth]  = lo[LO_W-1:0];
                    sha_at[depth] = sha[SH_W-1:0];
                    imm = mid;
                    depth++;
                end
            end
        end
        for (int i = depth - 1; i >= 0; i--) begin
            if (neg_at[i]) begin
                put_instr(OPK_SUB, '0, rd, '0);
            end else begin
                if (lo_at[i] != '0)
                    put_instr(OPK_ADDI, rd, '0, IMM_W'(lo_at[i]));
                if (sha_at[i] != '0)
                    put_instr(OPK_SLLI, rd, '0, IMM_W'(sha_at[i]));
            end
        end
        for (int i = 0; i < seq_len; i++) begin
            want.instr = seq_buf[i];
            want.last  = (i == seq_len - 1);
            pending_instrs.push_back(want);
        end
    endfunction

    // Offer one constant and return at the edge where it is taken.
    task automatic offer_constant(input logic [XLEN-1:0] value, input logic [XLEN-1:0] addr,
                                  input logic [REG_W-1:0] rd);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.value        <= value;
        in_ch.code_address <= addr;
        in_ch.dest_reg     <= rd;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    initial begin : stimulus
        t_const_row      row;
        t_exp_instr      want;
        logic [XLEN-1:0] value, addr;
        logic [31:0]     r32;
        logic [REG_W-1:0] rd;
        int unsigned     waited;
        i_rst_n            <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.value        <= '0;
        in_ch.code_address <= '0;
        in_ch.dest_reg     <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            row = const_rows[i];
            offer_constant(row.value, row.addr, row.rd);
            if (row.fixed_exp) begin
                want.instr.kind = row.kind;
                want.instr.rd   = row.rd;
                want.instr.rs1  = '0;
                want.instr.rs2  = '0;
                want.instr.imm  = row.imm;
                want.last       = 1'b1;
                pending_instrs.push_back(want);
            end else begin
                queue_expected_instrs(row.value, row.addr, row.rd);
            end
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == HOLD_AT)
                hold_req = 1'b1;
            if (n == N_RANDOM - N_CALM)
                idle_on = 1'b0;
            r32  = $urandom;
            addr = {$urandom, $urandom};
            case ($urandom_range(0, 9))
                0:       addr = '0;
                1:       addr = '1;
                default: ;
            endcase
            case ($urandom_range(0, 7))
                0: value = {{52{r32[11]}}, r32[11:0]};
                1: value = addr + {{32{r32[31]}}, r32};
                2: value = {{32{r32[31]}}, r32};
                3: value = {$urandom, $urandom};
                4: value = {{32{r32[31]}}, r32} << $urandom_range(0, 63);
                5: value = -({44'd0, r32[19:0]} << $urandom_range(12, 63));
                6: value = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
                default: value = ~({$urandom, $urandom} & {$urandom, $urandom});
            endcase
            rd = REG_W'($urandom_range(0, 31));
            offer_constant(value, addr, rd);
            queue_expected_instrs(value, addr, rd);
        end
        in_ch.valid <= 1'b0;

        waited = 0;
        while (pending_instrs.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_instrs.size() != 0) begin
            $display("%0t: %0d expected instructions never arrived", $time,
                     pending_instrs.size());
            error_count++;
        end
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Output side: random stall bursts plus one long hold to back up the input.
    initial begin : sink_side
        int unsigned stall_left;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else if (hold_req) begin
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                stall_left = HOLD_CYCLES - 1;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                out_ch.ready <= 1'b0;
                stall_left = $urandom_range(0, 5);
            end else begin
                out_ch.ready <= 1'b1;
            end
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin : check_instr
        t_exp_instr want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_instrs.size() == 0) begin
                $display("%0t: unexpected instr kind=%0d rd=%0d rs1=%0d rs2=%0d imm=%05h last=%0b",
                         $time, out_ch.opcode_kind, out_ch.rd_num, out_ch.rs1_num,
                         out_ch.rs2_num, out_ch.imm_bits, out_ch.last_instr);
                error_count++;
            end else begin
                want = pending_instrs.pop_front();
                if (out_ch.opcode_kind !== want.instr.kind || out_ch.rd_num !== want.instr.rd ||
                    out_ch.rs1_num !== want.instr.rs1 || out_ch.rs2_num !== want.instr.rs2 ||
                    out_ch.imm_bits !== want.instr.imm || out_ch.last_instr !== want.last) begin
                    $display("%0t: mismatch expected kind=%0d rd=%0d rs1=%0d rs2=%0d imm=%05h last=%0b",
                             $time, want.instr.kind, want.instr.rd, want.instr.rs1,
                             want.instr.rs2, want.instr.imm, want.last);
                    $display("%0t:          actual   kind=%0d rd=%0d rs1=%0d rs2=%0d imm=%05h last=%0b",
                             $time, out_ch.opcode_kind, out_ch.rd_num, out_ch.rs1_num,
                             out_ch.rs2_num, out_ch.imm_bits, out_ch.last_instr);
                    error_count++;
                end
            end
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("%0t: timeout after %0d cycles", $time, cycles);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
